FILE: hdl/rkm_pkg.sv
// ============================================================================
// rkm_pkg
// Shared types, constants and elaboration-time table builders for the
// Rabin-Karp matcher.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rkm_pkg;

  // Field widths of the stream words
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned MATCH_W  = 24;

  // Hash arithmetic
  localparam int unsigned HASH_W = 30;
  localparam logic [HASH_W-1:0] HASH_MOD = HASH_W'(1000000007);
  localparam longint unsigned HASH_MOD_L = 64'd1000000007;
  localparam longint unsigned HASH_BASE_L = 64'd37;
  localparam longint unsigned CHAR_OFFSET_L = 64'd96;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_PAT_DEF = 64;
  localparam int unsigned INDEX_W_DEF = 24;

  // Result queue
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  // Operation carried down the pipeline after the front end has decided it
  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PAT,
    OP_TEXT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic              full;   // a whole window of text has arrived
    logic              empty;  // pattern is empty: every text char matches
  } item_t;

  // One entry for each value of a 4-bit nibble of the character byte
  typedef logic [15:0][HASH_W-1:0] nib_tab_t;

  // 37^idx mod m
  function automatic logic [HASH_W-1:0] weight(input int unsigned idx);
    longint unsigned acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < idx; i++) begin
      acc = (acc * HASH_BASE_L) % HASH_MOD_L;
    end
    return HASH_W'(acc);
  endfunction

  // (16 * h * w) mod m for each high nibble h
  function automatic nib_tab_t hi_table(input logic [HASH_W-1:0] w);
    nib_tab_t        tab;
    longint unsigned wl;
    wl = 64'(w);
    for (int unsigned h = 0; h < 16; h++) begin
      tab[h] = HASH_W'((64'(16 * h) * wl) % HASH_MOD_L);
    end
    return tab;
  endfunction

  // ((l - 96) * w) mod m for each low nibble l; the character offset rides here
  function automatic nib_tab_t lo_table(input logic [HASH_W-1:0] w);
    nib_tab_t        tab;
    longint unsigned wl;
    longint unsigned neg;
    wl  = 64'(w);
    neg = (CHAR_OFFSET_L * wl) % HASH_MOD_L;
    for (int unsigned l = 0; l < 16; l++) begin
      tab[l] = HASH_W'(((64'(l) * wl) % HASH_MOD_L + HASH_MOD_L - neg) % HASH_MOD_L);
    end
    return tab;
  endfunction

  // (a + b) mod m for a, b already below m
  function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HASH_MOD}) begin
      s = s - {1'b0, HASH_MOD};
    end
    return s[HASH_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rkm_front.sv
// ============================================================================
// rkm_front
// Front end: decodes accepted words, keeps pattern length and text index,
// and issues one registered operation per word into the pipeline.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rkm_front #(
  parameter int unsigned MAX_PAT     = rkm_pkg::MAX_PAT_DEF,
  parameter int unsigned INDEX_WIDTH = rkm_pkg::INDEX_W_DEF,
  parameter int unsigned LEN_W       = $clog2(rkm_pkg::MAX_PAT_DEF + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  rkm_pkg::action_t              action,
  input  logic [rkm_pkg::CODE_W-1:0]    code,
  output rkm_pkg::item_t                item,
  output logic [LEN_W-1:0]              len,
  output logic [INDEX_WIDTH-1:0]        start
);

  localparam int unsigned CMP_W = (INDEX_WIDTH > LEN_W) ? INDEX_WIDTH : LEN_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAT);

  logic [LEN_W-1:0]       pat_len, pat_len_next;
  logic [INDEX_WIDTH-1:0] text_index, text_index_next;
  logic [INDEX_WIDTH-1:0] count;
  logic [CMP_W-1:0]       count_ext, len_ext, gap;
  rkm_pkg::item_t         item_next;
  logic [INDEX_WIDTH-1:0] start_next;

  always_comb begin
    pat_len_next    = pat_len;
    text_index_next = text_index;
    count           = text_index + INDEX_WIDTH'(1);
    count_ext       = CMP_W'(count);
    len_ext         = CMP_W'(pat_len);
    gap             = count_ext - len_ext;

    item_next.op    = rkm_pkg::OP_NONE;
    item_next.code  = code;
    item_next.full  = (count_ext >= len_ext);
    item_next.empty = (pat_len == '0);
    // An empty pattern reports the char's own index
    start_next      = item_next.empty ? text_index : gap[INDEX_WIDTH-1:0];

    if (accept) begin
      unique case (action)
        rkm_pkg::ACT_CLEAR: begin
          pat_len_next    = '0;
          text_index_next = '0;
          item_next.op    = rkm_pkg::OP_CLEAR;
        end
        rkm_pkg::ACT_RESTART: begin
          text_index_next = '0;
        end
        rkm_pkg::ACT_PATTERN: begin
          // drop pattern chars once text has started or the pattern is full
          if (text_index == '0 && pat_len < LEN_MAX) begin
            item_next.op = rkm_pkg::OP_PAT;
            pat_len_next = pat_len + LEN_W'(1);
          end
        end
        rkm_pkg::ACT_TEXT: begin
          // hold at the saturated index and drop the char
          if (text_index != '1) begin
            item_next.op    = rkm_pkg::OP_TEXT;
            text_index_next = count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len    <= '0;
      text_index <= '0;
      item.op    <= rkm_pkg::OP_NONE;
    end else begin
      pat_len    <= pat_len_next;
      text_index <= text_index_next;
      item       <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    len   <= pat_len;
    start <= start_next;
  end

endmodule

`default_nettype wire

FILE: hdl/rkm_cell.sv
// ============================================================================
// rkm_cell
// One position of the window chain: weights the current char by 37^IDX and
// adds it to the partial window sum handed over by the previous cell.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rkm_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = $clog2(rkm_pkg::MAX_PAT_DEF + 1)
) (
  input  logic                          clk,
  input  logic [rkm_pkg::CODE_W-1:0]    code,
  input  logic                          adv,
  input  logic [rkm_pkg::HASH_W-1:0]    acc_in,
  input  logic [rkm_pkg::HASH_W-1:0]    p_hash,
  input  logic [LEN_W-1:0]              pat_pos,
  input  logic [LEN_W-1:0]              win_len,
  output logic [rkm_pkg::HASH_W-1:0]    acc,
  output logic [rkm_pkg::HASH_W-1:0]    pat_term,
  output logic                          hit
);

  localparam logic [rkm_pkg::HASH_W-1:0] WEIGHT = rkm_pkg::weight(IDX);
  localparam rkm_pkg::nib_tab_t HI_TAB = rkm_pkg::hi_table(WEIGHT);
  localparam rkm_pkg::nib_tab_t LO_TAB = rkm_pkg::lo_table(WEIGHT);
  localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] WIN = LEN_W'(IDX + 1);

  logic [rkm_pkg::HASH_W-1:0] term;

  // char value times 37^IDX, mod m
  always_ff @(posedge clk) begin
    term <= rkm_pkg::mod_add(HI_TAB[code[7:4]], LO_TAB[code[3:0]]);
  end

  // acc holds the sum over the last IDX+1 text chars
  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= rkm_pkg::mod_add(acc_in, term);
    end
  end

  assign hit      = (win_len == WIN) && (acc == p_hash);
  assign pat_term = (pat_pos == POS) ? term : '0;

endmodule

`default_nettype wire

FILE: hdl/rkm_out_fifo.sv
// ============================================================================
// rkm_out_fifo
// Small result queue between the match pipeline and the output stream.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rkm_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [rkm_pkg::MATCH_W-1:0]   push_data,
  input  logic                          pop,
  output logic                          valid,
  output logic [rkm_pkg::MATCH_W-1:0]   data,
  output logic [rkm_pkg::OCNT_W-1:0]    count
);

  logic [rkm_pkg::MATCH_W-1:0] slots [rkm_pkg::OUT_DEPTH];
  logic [rkm_pkg::OPTR_W-1:0]  wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rkm_pkg::OPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rkm_pkg::OPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + rkm_pkg::OCNT_W'(1);
        2'b01:   count <= count - rkm_pkg::OCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign data  = slots[rd_ptr];

endmodule

`default_nettype wire

FILE: hdl/rabin_karp_matcher_core.sv
// ============================================================================
// rabin_karp_matcher_core
// Streaming Rabin-Karp matcher, base 37, modulus 1000000007. Each word on the
// input stream carries an action in tuser and a character byte in tdata:
// clear all, append a pattern char, append a text char, or restart the text
// while keeping the pattern. Every text char that completes a window whose
// hash equals the pattern hash emits the zero-based start index of that
// window on the output stream; hash collisions are reported like true
// matches, and an empty pattern matches at every index. Pattern chars past
// MAX_PAT, or arriving after text has started, are dropped; the text index
// saturates at 2^INDEX_WIDTH - 1 and chars beyond it are dropped. The block
// takes one word per cycle while the input is not stalled. A text word's
// result reaches the output through the front-end register, each cell's
// weighting-table register, the chain add and the window compare and queue
// write. The input stalls only when the eight-entry result queue, counted
// together with text words still in the pipeline, would overflow; results
// waiting on the output never hold the input back otherwise.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rabin_karp_matcher_core #(
  parameter int unsigned MAX_PAT     = rkm_pkg::MAX_PAT_DEF,
  parameter int unsigned INDEX_WIDTH = rkm_pkg::INDEX_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rkm_pkg::CODE_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic [rkm_pkg::ACTION_W-1:0]   s_axis_tuser,   // [1:0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rkm_pkg::MATCH_W-1:0]    m_axis_tdata    // [23:0] match_start
);

  localparam int unsigned LEN_W  = $clog2(MAX_PAT + 1);
  localparam int unsigned WIDE_W = (INDEX_WIDTH > rkm_pkg::MATCH_W) ?
                                   INDEX_WIDTH : rkm_pkg::MATCH_W;

  // --------------------------------------------------------------------------
  // Stage 1: front end decides what each accepted word does
  // --------------------------------------------------------------------------
  logic                   in_accept;
  rkm_pkg::item_t         s1_item, s2_item, s3_item;
  logic [LEN_W-1:0]       s1_len, s2_len, s3_len;
  logic [INDEX_WIDTH-1:0] s1_start, s2_start, s3_start;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  rkm_front #(
    .MAX_PAT     (MAX_PAT),
    .INDEX_WIDTH (INDEX_WIDTH),
    .LEN_W       (LEN_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .action (rkm_pkg::action_t'(s_axis_tuser)),
    .code   (s_axis_tdata),
    .item   (s1_item),
    .len    (s1_len),
    .start  (s1_start)
  );

  // --------------------------------------------------------------------------
  // Stages 2 and 3: advance the operation tags alongside the cell chain.
  // Each cell weights the stage-1 char into its term register (stage 2),
  // then the chain shifts on a text char (stage 3 sees the new sums).
  // --------------------------------------------------------------------------
  logic [rkm_pkg::HASH_W-1:0] p_hash;     // weighted pattern hash
  logic [rkm_pkg::HASH_W-1:0] pat_sum;    // term of the pattern char in flight
  logic [rkm_pkg::HASH_W-1:0] pat_or;
  logic [rkm_pkg::HASH_W-1:0] acc_out   [MAX_PAT];
  logic [rkm_pkg::HASH_W-1:0] pat_terms [MAX_PAT];
  logic [MAX_PAT-1:0]         hits;
  logic                       chain_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_item.op <= rkm_pkg::OP_NONE;
      s3_item.op <= rkm_pkg::OP_NONE;
      p_hash     <= '0;
    end else begin
      s2_item <= s1_item;
      s3_item <= s2_item;
      // fold each pattern char into the pattern hash in arrival order
      priority if (s3_item.op == rkm_pkg::OP_CLEAR) begin
        p_hash <= '0;
      end else if (s3_item.op == rkm_pkg::OP_PAT) begin
        p_hash <= rkm_pkg::mod_add(p_hash, pat_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_len   <= s1_len;
    s3_len   <= s2_len;
    s2_start <= s1_start;
    s3_start <= s2_start;
    if (s2_item.op == rkm_pkg::OP_PAT) begin
      pat_sum <= pat_or;
    end
  end

  assign chain_adv = (s2_item.op == rkm_pkg::OP_TEXT);

  for (genvar i = 0; i < MAX_PAT; i++) begin : g_cell
    logic [rkm_pkg::HASH_W-1:0] acc_in;
    if (i == 0) begin : g_head
      assign acc_in = '0;   // a new window starts empty
    end else begin : g_link
      assign acc_in = acc_out[i-1];
    end

    rkm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .code     (s1_item.code),
      .adv      (chain_adv),
      .acc_in   (acc_in),
      .p_hash   (p_hash),
      .pat_pos  (s2_len),
      .win_len  (s3_len),
      .acc      (acc_out[i]),
      .pat_term (pat_terms[i]),
      .hit      (hits[i])
    );
  end

  // Only the cell at the pattern position drives a nonzero term
  always_comb begin
    pat_or = '0;
    for (int i = 0; i < MAX_PAT; i++) begin
      pat_or = pat_or | pat_terms[i];
    end
  end

  // --------------------------------------------------------------------------
  // Window compare and result queue. The cell holding a full pattern length
  // of text compares its sum with the pattern hash; with both sides scaled
  // to the window start this is the same test as the prefix-difference form.
  // --------------------------------------------------------------------------
  logic                          push;
  logic [WIDE_W-1:0]             start_wide;
  logic                          out_pop;
  logic [rkm_pkg::OCNT_W-1:0]    fifo_count;
  logic [rkm_pkg::OCNT_W-1:0]    in_flight;

  assign push = (s3_item.op == rkm_pkg::OP_TEXT) &&
                (s3_item.empty || (s3_item.full && (|hits)));
  assign start_wide = WIDE_W'(s3_start);
  assign out_pop    = m_axis_tvalid && m_axis_tready;

  rkm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (start_wide[rkm_pkg::MATCH_W-1:0]),
    .pop       (out_pop),
    .valid     (m_axis_tvalid),
    .data      (m_axis_tdata),
    .count     (fifo_count)
  );

  // Count every text word that may still push a result, and take a new word
  // only while the queue has room for all of them plus this one.
  assign in_flight = rkm_pkg::OCNT_W'(s1_item.op == rkm_pkg::OP_TEXT) +
                     rkm_pkg::OCNT_W'(s2_item.op == rkm_pkg::OP_TEXT) +
                     rkm_pkg::OCNT_W'(s3_item.op == rkm_pkg::OP_TEXT);

  assign s_axis_tready = (fifo_count + in_flight) < rkm_pkg::OCNT_W'(rkm_pkg::OUT_DEPTH);

endmodule

`default_nettype wire

FILE: hdl/rkm_checker.sv
// ============================================================================
// rkm_checker
// Port-level checks for the Rabin-Karp matcher, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rkm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [rkm_pkg::ACTION_W-1:0]   s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rkm_pkg::MATCH_W-1:0]    m_axis_tdata
);

  // Out of reset: queue empty and input open
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (s_axis_tready && !m_axis_tvalid))
    else $error("matcher not idle after reset");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

  // A result on an idle output comes from an earlier accepted text word
  a_result_from_text: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == rkm_pkg::ACT_TEXT), 4))
    else $error("result without a matching text word");

  // With no result waiting the queue always has room
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result queue");

endmodule

bind rabin_karp_matcher_core rkm_checker u_rkm_checker (.*);

`default_nettype wire
